// ----- sv/drd_pkg.sv -----
package drd_pkg;

   localparam int FRAME_BYTES  = 64;
   localparam int MAX_PENDING  = 15;
   localparam int RESULT_LIMIT = 64;
   localparam int HDR_BYTES    = 5;

   localparam int COUNT_W = $clog2(FRAME_BYTES + 1);
   localparam int ADDR_W  = $clog2(FRAME_BYTES);
   localparam int PEND_W  = $clog2(MAX_PENDING + 1);
   localparam int HDR_W   = $clog2(HDR_BYTES);

   localparam int STR_LIMIT = (FRAME_BYTES - 1 < RESULT_LIMIT) ? FRAME_BYTES - 1 : RESULT_LIMIT;

   localparam logic [7:0] BYTE_TERM = 8'hFF;
   localparam logic [7:0] OP_OK     = 8'h01;
   localparam logic [7:0] OP_ERR_HI = 8'h1B;
   localparam logic [7:0] OP_TOUCH  = 8'h65;
   localparam logic [7:0] OP_STRING = 8'h70;
   localparam logic [7:0] OP_PAGE   = 8'h66;
   localparam logic [7:0] OP_INT    = 8'h71;

   typedef enum logic [2:0] {
      KIND_OK        = 3'd0,
      KIND_ERROR     = 3'd1,
      KIND_TOUCH     = 3'd2,
      KIND_STRING    = 3'd3,
      KIND_PAGE      = 3'd4,
      KIND_INT       = 3'd5,
      KIND_UNHANDLED = 3'd6,
      KIND_UNMATCHED = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUT_FF,
      ST_PUT_DATA,
      ST_FINISH,
      ST_RSP,
      ST_STR_RD,
      ST_STR_OUT
   } state_type;

   typedef struct packed {
      logic take;
      logic put_ff;
      logic put_data;
      logic finish;
      logic str_read;
      logic str_next;
      logic sel_str;
   } cmd_type;

   typedef struct packed {
      logic is_cmd;
      logic is_term;
      logic run_full;
      logic run_zero;
      logic run_one;
      logic str_multi;
      logic str_last;
   } status_type;

endpackage

// ----- sv/drd_req_if.sv -----
interface drd_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

// ----- sv/drd_rsp_if.sv -----
interface drd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  code;
   logic [7:0]  page;
   logic [7:0]  component;
   logic [7:0]  touch_state;
   logic [31:0] value;
   logic [7:0]  text_byte;
   logic        byte_valid;
   logic        last;

   modport source (output valid, output kind, output code, output page, output component,
                   output touch_state, output value, output text_byte, output byte_valid,
                   output last, input ready);
   modport sink (input valid, input kind, input code, input page, input component,
                 input touch_state, input value, input text_byte, input byte_valid,
                 input last, output ready);
endinterface

// ----- sv/display_response_deframer.sv -----
// Display reply deframer. Each req transfer carries either a received byte
// (mode 0) or a command-issued event (mode 1). A data byte first flushes
// each held-back 0xFF byte into the frame buffer (one buffer write per
// cycle, at most two of them), then is written itself. The third 0xFF
// of a run closes the frame: it is classified in the finish state, then
// one rsp transfer follows for most kinds. A string reply streams its
// characters from the frame buffer through the buffer's registered read
// port, a read state before each output state; the final transfer has last
// set. The buffer needs no clearing after reset.
module display_response_deframer
   import drd_pkg::*;
(
   input logic     clock,
   input logic     reset,
   drd_req_if.sink   req_ch,
   drd_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   drd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   drd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .mode        (req_ch.mode),
      .rx_byte     (req_ch.rx_byte),
      .cmd         (cmd),
      .status      (status),
      .kind        (rsp_ch.kind),
      .code        (rsp_ch.code),
      .page        (rsp_ch.page),
      .component   (rsp_ch.component),
      .touch_state (rsp_ch.touch_state),
      .value       (rsp_ch.value),
      .text_byte   (rsp_ch.text_byte),
      .byte_valid  (rsp_ch.byte_valid),
      .last        (rsp_ch.last)
   );

endmodule

// ----- sv/drd_ram.sv -----
module drd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/drd_ctrl.sv -----
module drd_ctrl
   import drd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (status.is_cmd) begin
                  state_in = ST_IDLE;
               end else if (status.is_term) begin
                  state_in = status.run_full ? ST_FINISH : ST_IDLE;
               end else if (status.run_zero) begin
                  state_in = ST_PUT_DATA;
               end else begin
                  state_in = ST_PUT_FF;
               end
            end
         end
         ST_PUT_FF: begin
            if (status.run_one) begin
               state_in = ST_PUT_DATA;
            end
         end
         ST_PUT_DATA: state_in = ST_IDLE;
         ST_FINISH:   state_in = status.str_multi ? ST_STR_RD : ST_RSP;
         ST_RSP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_STR_RD: state_in = ST_STR_OUT;
         ST_STR_OUT: begin
            if (rsp_ready) begin
               state_in = status.str_last ? ST_IDLE : ST_STR_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_PUT_FF:   cmd.put_ff = 1'b1;
         ST_PUT_DATA: cmd.put_data = 1'b1;
         ST_FINISH:   cmd.finish = 1'b1;
         ST_RSP:      rsp_valid = 1'b1;
         ST_STR_RD:   cmd.str_read = 1'b1;
         ST_STR_OUT: begin
            rsp_valid    = 1'b1;
            cmd.sel_str  = 1'b1;
            cmd.str_next = rsp_ready && !status.str_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- sv/drd_datapath.sv -----
module drd_datapath
   import drd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        mode,
   input  logic [7:0]  rx_byte,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [2:0]  kind,
   output logic [7:0]  code,
   output logic [7:0]  page,
   output logic [7:0]  component,
   output logic [7:0]  touch_state,
   output logic [31:0] value,
   output logic [7:0]  text_byte,
   output logic        byte_valid,
   output logic        last
);

   logic [1:0]         run_ff, run_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PEND_W-1:0]  pending_ff, pending_in;
   logic [7:0]         byte_ff;
   logic [7:0]         hdr_ff [HDR_BYTES];
   logic [COUNT_W-1:0] str_n_ff;
   logic [COUNT_W-1:0] idx_ff;
   kind_type           kind_ff;
   logic [7:0]         code_ff, page_ff, comp_ff, tstate_ff;
   logic [31:0]        value_ff;

   logic               put;
   logic               wr_en;
   logic [7:0]         wr_data;
   logic [7:0]         rd_data;
   logic [7:0]         op;
   logic               reply;
   logic [COUNT_W-1:0] str_len;
   kind_type           cls;
   kind_type           res_kind;

   assign op      = hdr_ff[0];
   assign put     = cmd.put_ff || cmd.put_data;
   assign wr_en   = put && (count_ff < COUNT_W'(FRAME_BYTES));
   assign wr_data = cmd.put_ff ? BYTE_TERM : byte_ff;
   assign str_len = count_ff - COUNT_W'(1);

   always_comb begin
      priority if (count_ff == COUNT_W'(1) && op == OP_OK) begin
         cls = KIND_OK;
      end else if (count_ff == COUNT_W'(1) && op <= OP_ERR_HI) begin
         cls = KIND_ERROR;
      end else if (count_ff == COUNT_W'(4) && op == OP_TOUCH) begin
         cls = KIND_TOUCH;
      end else if (op == OP_STRING) begin
         cls = KIND_STRING;
      end else if (count_ff == COUNT_W'(2) && op == OP_PAGE) begin
         cls = KIND_PAGE;
      end else if (count_ff == COUNT_W'(5) && op == OP_INT) begin
         cls = KIND_INT;
      end else begin
         cls = KIND_UNHANDLED;
      end
      if (count_ff == '0) begin
         cls = KIND_UNHANDLED;
      end
   end

   assign reply    = (cls != KIND_TOUCH) && (cls != KIND_UNHANDLED);
   assign res_kind = (reply && pending_ff == '0) ? KIND_UNMATCHED : cls;

   assign status.is_cmd    = mode;
   assign status.is_term   = (rx_byte == BYTE_TERM);
   assign status.run_full  = (run_ff == 2'd2);
   assign status.run_zero  = (run_ff == 2'd0);
   assign status.run_one   = (run_ff == 2'd1);
   assign status.str_multi = (cls == KIND_STRING) && (pending_ff != '0)
                             && (count_ff > COUNT_W'(1));
   assign status.str_last  = (idx_ff == str_n_ff);

   always_comb begin
      run_in     = run_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      if (cmd.take) begin
         priority if (mode) begin
            if (pending_ff != PEND_W'(MAX_PENDING)) begin
               pending_in = pending_ff + PEND_W'(1);
            end
         end else if (rx_byte == BYTE_TERM) begin
            run_in = (run_ff == 2'd2) ? 2'd0 : run_ff + 2'd1;
         end else begin
            run_in = run_ff;
         end
      end
      if (cmd.put_ff) begin
         run_in = run_ff - 2'd1;
      end
      if (wr_en) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (cmd.finish) begin
         count_in = '0;
         if (reply && pending_ff != '0) begin
            pending_in = pending_ff - PEND_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         run_ff     <= run_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         byte_ff <= rx_byte;
      end
      if (wr_en && count_ff < COUNT_W'(HDR_BYTES)) begin
         hdr_ff[count_ff[HDR_W-1:0]] <= wr_data;
      end
      if (cmd.finish) begin
         idx_ff <= COUNT_W'(1);
      end else if (cmd.str_next) begin
         idx_ff <= idx_ff + COUNT_W'(1);
      end
      if (cmd.finish) begin
         str_n_ff  <= (str_len > COUNT_W'(STR_LIMIT)) ? COUNT_W'(STR_LIMIT) : str_len;
         kind_ff   <= res_kind;
         code_ff   <= (count_ff == '0) ? 8'h00 : op;
         unique case (res_kind)
            KIND_TOUCH: begin
               page_ff   <= hdr_ff[1];
               comp_ff   <= hdr_ff[2];
               tstate_ff <= hdr_ff[3];
               value_ff  <= '0;
            end
            KIND_PAGE: begin
               page_ff   <= hdr_ff[1];
               comp_ff   <= 8'h00;
               tstate_ff <= 8'h00;
               value_ff  <= '0;
            end
            KIND_INT: begin
               page_ff   <= 8'h00;
               comp_ff   <= 8'h00;
               tstate_ff <= 8'h00;
               value_ff  <= {hdr_ff[4], hdr_ff[3], hdr_ff[2], hdr_ff[1]};
            end
            default: begin
               page_ff   <= 8'h00;
               comp_ff   <= 8'h00;
               tstate_ff <= 8'h00;
               value_ff  <= '0;
            end
         endcase
      end
   end

   drd_ram #(
      .WIDTH(8),
      .DEPTH(FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.str_read),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      if (cmd.sel_str) begin
         kind        = KIND_STRING;
         code        = code_ff;
         page        = 8'h00;
         component   = 8'h00;
         touch_state = 8'h00;
         value       = '0;
         text_byte   = rd_data;
         byte_valid  = 1'b1;
         last        = status.str_last;
      end else begin
         kind        = kind_ff;
         code        = code_ff;
         page        = page_ff;
         component   = comp_ff;
         touch_state = tstate_ff;
         value       = value_ff;
         text_byte   = 8'h00;
         byte_valid  = 1'b0;
         last        = 1'b1;
      end
   end

endmodule

// ----- tb/sv/tb_display_response_deframer.sv -----
`timescale 1ns / 100ps

module tb_display_response_deframer;
   import drd_pkg::*;

   typedef struct packed {
      logic       mode;
      logic [7:0] data;
   } serial_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  code;
      logic [7:0]  page;
      logic [7:0]  component;
      logic [7:0]  touch_state;
      logic [31:0] value;
      logic [7:0]  text_byte;
      logic        byte_valid;
      logic        last;
   } reply_type;

   logic clock;
   logic reset;

   drd_req_if req_ch ();
   drd_rsp_if rsp_ch ();

   display_response_deframer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // stimulus and expectations
   serial_item_type pending_items[$];
   logic [7:0]      frame_body[$];
   reply_type       expected_replies[$];

   // shadow of the deframer state
   logic [7:0] frame_mem[FRAME_BYTES];
   int         frame_len;
   int         ff_run;
   int         cmds_waiting;

   int mismatches;
   int items_taken;
   bit req_took;

   // sender pacing
   serial_item_type drv_item;
   bit              drv_valid;
   int              burst_left;
   int              gap_left;

   // receiver pacing
   int ready_style;
   int style_left;
   bit rdy;
   int holdoff_left;
   bit holdoff_done;

   function automatic reply_type make_reply(kind_type k, logic [7:0] code, logic [7:0] page,
                                            logic [7:0] comp, logic [7:0] tstate,
                                            logic [31:0] value, logic [7:0] text, logic bv,
                                            logic last);
      reply_type r;
      r.kind        = k;
      r.code        = code;
      r.page        = page;
      r.component   = comp;
      r.touch_state = tstate;
      r.value       = value;
      r.text_byte   = text;
      r.byte_valid  = bv;
      r.last        = last;
      return r;
   endfunction

   function automatic string reply_str(reply_type r);
      return $sformatf("kind=%0d code=%h page=%h comp=%h state=%h value=%h text=%h bv=%b last=%b",
                       r.kind, r.code, r.page, r.component, r.touch_state, r.value,
                       r.text_byte, r.byte_valid, r.last);
   endfunction

   task automatic store_byte(input logic [7:0] b);
      if (frame_len < FRAME_BYTES) begin
         frame_mem[frame_len] = b;
         frame_len++;
      end
   endtask

   // Advance the shadow state by one accepted transfer and queue the replies it causes.
   task automatic deframe_byte(input logic mode, input logic [7:0] b);
      int         i;
      int         n;
      logic [7:0] op;
      kind_type   k;
      if (mode) begin
         if (cmds_waiting < MAX_PENDING) cmds_waiting++;
      end else if (b == BYTE_TERM) begin
         ff_run++;
         if (ff_run >= 3) begin
            ff_run = 0;
            if (frame_len == 0) begin
               expected_replies.push_back(make_reply(KIND_UNHANDLED, 0, 0, 0, 0, 0, 0, 0, 1));
            end else begin
               op = frame_mem[0];
               if (frame_len == 1 && op == OP_OK) k = KIND_OK;
               else if (frame_len == 1 && op <= OP_ERR_HI) k = KIND_ERROR;
               else if (frame_len == 4 && op == OP_TOUCH) k = KIND_TOUCH;
               else if (op == OP_STRING) k = KIND_STRING;
               else if (frame_len == 2 && op == OP_PAGE) k = KIND_PAGE;
               else if (frame_len == 5 && op == OP_INT) k = KIND_INT;
               else k = KIND_UNHANDLED;

               if (k == KIND_TOUCH) begin
                  expected_replies.push_back(make_reply(KIND_TOUCH, op, frame_mem[1],
                     frame_mem[2], frame_mem[3], 0, 0, 0, 1));
               end else if (k == KIND_UNHANDLED) begin
                  expected_replies.push_back(make_reply(KIND_UNHANDLED, op, 0, 0, 0, 0, 0, 0, 1));
               end else if (cmds_waiting == 0) begin
                  expected_replies.push_back(make_reply(KIND_UNMATCHED, op, 0, 0, 0, 0, 0, 0, 1));
               end else begin
                  cmds_waiting--;
                  case (k)
                     KIND_OK, KIND_ERROR: begin
                        expected_replies.push_back(make_reply(k, op, 0, 0, 0, 0, 0, 0, 1));
                     end
                     KIND_PAGE: begin
                        expected_replies.push_back(make_reply(KIND_PAGE, op, frame_mem[1],
                           0, 0, 0, 0, 0, 1));
                     end
                     KIND_INT: begin
                        expected_replies.push_back(make_reply(KIND_INT, op, 0, 0, 0,
                           {frame_mem[4], frame_mem[3], frame_mem[2], frame_mem[1]}, 0, 0, 1));
                     end
                     default: begin
                        n = frame_len - 1;
                        if (n == 0) begin
                           expected_replies.push_back(make_reply(KIND_STRING, op, 0, 0, 0,
                              0, 0, 0, 1));
                        end else begin
                           if (n > RESULT_LIMIT) n = RESULT_LIMIT;
                           for (i = 0; i < n; i++)
                              expected_replies.push_back(make_reply(KIND_STRING, op, 0, 0, 0,
                                 0, frame_mem[i + 1], 1, (i == n - 1)));
                        end
                     end
                  endcase
               end
            end
            frame_len = 0;
         end
      end else begin
         for (i = 0; i < ff_run; i++) store_byte(BYTE_TERM);
         ff_run = 0;
         store_byte(b);
      end
   endtask

   task automatic queue_item(input logic mode, input logic [7:0] b);
      serial_item_type it;
      it.mode = mode;
      it.data = b;
      pending_items.push_back(it);
   endtask

   task automatic queue_cmds(input int n);
      int i;
      for (i = 0; i < n; i++) queue_item(1'b1, 8'($urandom_range(0, 255)));
   endtask

   task automatic queue_frame();
      int i;
      for (i = 0; i < frame_body.size(); i++) queue_item(1'b0, frame_body[i]);
      for (i = 0; i < 3; i++) queue_item(1'b0, BYTE_TERM);
      frame_body.delete();
   endtask

   // last payload byte must not be 0xFF or it would merge with the terminator
   function automatic logic [7:0] body_byte(bit tail);
      if (tail) return 8'($urandom_range(0, 254));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_random_part(input int target);
      int base;
      int r;
      int i;
      int n;
      base = pending_items.size();
      while (pending_items.size() - base < target) begin
         r = $urandom_range(0, 99);
         if (r < 22) begin
            queue_cmds($urandom_range(1, 4));
         end else if (r < 32) begin
            frame_body.push_back(OP_OK);
            queue_frame();
         end else if (r < 40) begin
            frame_body.push_back(8'($urandom_range(0, 8'h1B)));
            queue_frame();
         end else if (r < 50) begin
            frame_body.push_back(OP_TOUCH);
            frame_body.push_back(body_byte(0));
            frame_body.push_back(body_byte(0));
            frame_body.push_back(body_byte(1));
            queue_frame();
         end else if (r < 63) begin
            frame_body.push_back(OP_STRING);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
            for (i = 0; i < n; i++) frame_body.push_back(body_byte(i == n - 1));
            queue_frame();
         end else if (r < 70) begin
            frame_body.push_back(OP_PAGE);
            frame_body.push_back(body_byte(1));
            queue_frame();
         end else if (r < 78) begin
            frame_body.push_back(OP_INT);
            for (i = 0; i < 4; i++) frame_body.push_back(body_byte(i == 3));
            queue_frame();
         end else if (r < 86) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) frame_body.push_back(body_byte(i == n - 1));
            queue_frame();
         end else if (r < 93) begin
            // noise with short 0xFF runs, no terminator
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 2) == 0) begin
                  queue_item(1'b0, BYTE_TERM);
                  if ($urandom_range(0, 1)) queue_item(1'b0, BYTE_TERM);
               end
               queue_item(1'b0, body_byte(1));
            end
         end else begin
            // known opcode, random length (sometimes the right one)
            case ($urandom_range(0, 3))
               0: frame_body.push_back(OP_TOUCH);
               1: frame_body.push_back(OP_PAGE);
               2: frame_body.push_back(OP_INT);
               default: frame_body.push_back(OP_OK);
            endcase
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) frame_body.push_back(body_byte(i == n - 1));
            queue_frame();
         end
      end
   endtask

   task automatic queue_directed_part();
      int i;
      frame_body.push_back(OP_OK);                  // nothing pending
      queue_frame();
      queue_cmds(1);
      frame_body.push_back(OP_OK);
      queue_frame();
      queue_cmds(2);
      frame_body.push_back(8'h00);
      queue_frame();
      frame_body.push_back(OP_ERR_HI);
      queue_frame();
      frame_body.push_back(8'h1C);
      queue_frame();
      frame_body = '{OP_TOUCH, 8'hFF, 8'hFF, 8'h00}; // 0xFF run kept as data
      queue_frame();
      frame_body = '{OP_TOUCH, 8'h00, 8'h7F, 8'hFE};
      queue_frame();
      frame_body = '{OP_TOUCH, 8'h01, 8'h02};
      queue_frame();
      queue_item(1'b0, BYTE_TERM);                  // empty frame
      queue_item(1'b0, BYTE_TERM);
      queue_item(1'b0, BYTE_TERM);
      queue_cmds(6);
      frame_body.push_back(OP_STRING);              // empty string
      queue_frame();
      frame_body = '{OP_STRING, 8'h00, 8'h41, 8'hFF, 8'h42};
      queue_frame();
      frame_body = '{OP_PAGE, 8'h00};
      queue_frame();
      frame_body = '{OP_PAGE, 8'hFE};
      queue_frame();
      frame_body = '{OP_INT, 8'h78, 8'h56, 8'h34, 8'h12};
      queue_frame();
      frame_body = '{OP_INT, 8'hFF, 8'hFF, 8'h00, 8'h80};
      queue_frame();
      // overlong string, buffer full
      queue_cmds(18);
      frame_body.push_back(OP_STRING);
      for (i = 0; i < 70; i++) frame_body.push_back(8'(i + 8'h20));
      queue_frame();
      for (i = 0; i < 15; i++) begin             // drains the saturated count, then unmatched
         frame_body.push_back(OP_OK);
         queue_frame();
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         drv_valid = req_ch.valid;
         if (drv_valid && req_took) begin
            void'(pending_items.pop_front());
            drv_valid = 1'b0;
         end
         if (!drv_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_items.size() != 0) begin
               drv_valid = 1'b1;
               drv_item  = pending_items[0];
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_ch.valid   <= drv_valid;
         req_ch.mode    <= drv_item.mode;
         req_ch.rx_byte <= drv_item.data;
      end
   end

   // long receiver hold-off once traffic is under way
   always @(negedge clock) begin
      if (!reset) begin
         if (!holdoff_done && items_taken >= 150) begin
            holdoff_left <= 500;
            holdoff_done <= 1'b1;
         end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            ready_style = $urandom_range(0, 3);
            style_left  = $urandom_range(16, 80);
         end else begin
            style_left--;
         end
         case (ready_style)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = ($urandom_range(0, 4) != 0);
         endcase
         if (holdoff_left != 0) rdy = 1'b0;
         rsp_ch.ready <= rdy;
      end
   end

   // monitor: replies are checked before the same-edge transfer is predicted
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind        = rsp_ch.kind;
            got.code        = rsp_ch.code;
            got.page        = rsp_ch.page;
            got.component   = rsp_ch.component;
            got.touch_state = rsp_ch.touch_state;
            got.value       = rsp_ch.value;
            got.text_byte   = rsp_ch.text_byte;
            got.byte_valid  = rsp_ch.byte_valid;
            got.last        = rsp_ch.last;
            if (expected_replies.size() == 0) begin
               if (mismatches < 10) $display("unexpected reply: %s", reply_str(got));
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     $display("reply mismatch\n  exp: %s\n  got: %s",
                              reply_str(want), reply_str(got));
                  mismatches++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            deframe_byte(req_ch.mode, req_ch.rx_byte);
            items_taken++;
         end
      end
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.mode    = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      frame_len      = 0;
      ff_run         = 0;
      cmds_waiting   = 0;
      mismatches     = 0;
      items_taken    = 0;
      burst_left     = 1;
      gap_left       = 0;
      style_left     = 0;
      ready_style    = 0;
      holdoff_left   = 0;
      holdoff_done   = 1'b0;
      drv_item       = '0;

      queue_directed_part();
      queue_random_part(260 - pending_items.size());

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid) @(negedge clock);
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);

      if (mismatches == 0 && expected_replies.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/drd_pkg.sv
sv/drd_req_if.sv
sv/drd_rsp_if.sv
sv/drd_ram.sv
sv/drd_ctrl.sv
sv/drd_datapath.sv
sv/display_response_deframer.sv
tb/sv/tb_display_response_deframer.sv
